// ----- rtl/bldc_pkg.sv -----
// Shared constants and types of the backward LZ flag-byte decompressor.
`timescale 1ns / 1ps

package bldc_pkg;

    localparam int DATA_W        = 8;
    localparam int CNT_W         = 32;
    localparam int HIST_DEPTH    = 256;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);
    localparam int OUT_LANES     = 8;
    localparam int LANE_SLOTS    = 8;
    localparam int LANES         = (OUT_LANES > LANE_SLOTS) ? LANE_SLOTS :
                                   ((OUT_LANES < 1) ? 1 : OUT_LANES);
    localparam int LANE_IDX_W    = $clog2(LANE_SLOTS);
    localparam int VC_W          = 4;
    localparam int MIN_MATCH     = 3;
    localparam int TRAILER_BYTES = 4;
    localparam int TRAILER_W     = 3;
    localparam int RUN_W         = 9;
    localparam int S_TDATA_W     = 8;
    localparam int S_TUSER_W     = 1;
    localparam int M_PAYLOAD_W   = LANE_SLOTS * DATA_W + VC_W;
    localparam int M_TDATA_W     = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TUSER_W     = 2;
    localparam int USER_ERR      = 0;
    localparam int USER_DONE     = 1;

    typedef enum logic [4:0] {
        PH_PAD     = 5'b00001,
        PH_TRAILER = 5'b00010,
        PH_BODY    = 5'b00100,
        PH_FLAG    = 5'b01000,
        PH_LEN     = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHK   = 4'b0010,
        ST_WR    = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

// ----- rtl/bldc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bldc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/backward_lz_flag_decompressor.sv -----
// Top level of the backward LZ flag-byte decompressor.
// The block takes compressed bytes on the slave stream, last byte of the buffer first, with
// tuser set on the first byte of a stream. Trailing zero padding is skipped, the first
// nonzero byte becomes the flag and the four stored-size bytes are skipped; the expected
// size comes from the out_size register; the user is to write it through cfg_we and cfg_wdata
// only while idle, which the block itself does not enforce.
// Decoded bytes leave on the master stream in groups of up to eight, tlast marking the
// last group caused by one input item and tuser carrying the error and done flags.
// Each produced byte passes through a check state, which tests for the end of the run and
// presents the history read, and a write state, which writes the history and a lane; a
// full group or the end of a run then passes through a flush state that loads the output
// register. No new item is accepted while a token is being expanded.
// Reset clears all parse state, the size register and the output valid flag; the history
// needs no clearing because a copy never reaches beyond what the stream has written.
// When the receiver stalls, the finished group waits in the output register and the
// expansion pauses in the flush state until it is taken.
`timescale 1ns / 1ps

module backward_lz_flag_decompressor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bldc_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bldc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // data_byte
    input  logic [bldc_pkg::S_TUSER_W-1:0] s_axis_tuser,  // stream_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bldc_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte_0..7, valid_count
    output logic                           m_axis_tlast,  // run_last
    output logic [bldc_pkg::M_TUSER_W-1:0] m_axis_tuser   // decode_error, stream_done
);

    import bldc_pkg::*;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [DATA_W-1:0]      flag_reg, flag_next;
    logic [TRAILER_W-1:0]   skip_reg, skip_next;
    logic [DATA_W-1:0]      dist_reg, dist_next;
    logic [CNT_W-1:0]       prod_reg, prod_next;
    logic                   err_latch_reg, err_latch_next;
    logic [CNT_W-1:0]       size_reg, size_next;
    logic [RUN_W-1:0]       remain_reg, remain_next;
    logic [DATA_W-1:0]      lit_reg, lit_next;
    logic                   use_lit_reg, use_lit_next;
    logic [VC_W-1:0]        fill_reg, fill_next;
    logic [DATA_W-1:0]      lane_reg [LANE_SLOTS];
    logic [DATA_W-1:0]      lane_next [LANE_SLOTS];
    logic                   final_reg, final_next;
    logic                   run_err_reg, run_err_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic [M_TUSER_W-1:0]   m_user_reg, m_user_next;

    logic                   ram_we;
    logic [HIST_AW-1:0]     ram_waddr;
    logic [DATA_W-1:0]      ram_wdata;
    logic [HIST_AW-1:0]     ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;

    logic                   in_take;
    logic [DATA_W-1:0]      in_byte;
    logic                   in_start;
    phase_t                 eff_phase;
    logic [DATA_W-1:0]      eff_flag;
    logic [TRAILER_W-1:0]   eff_skip;
    logic [TRAILER_W-1:0]   skip_dec;
    logic [DATA_W-1:0]      eff_dist;
    logic [CNT_W-1:0]       eff_prod;
    logic                   eff_err;
    logic [DATA_W-1:0]      put_val;
    logic [M_TDATA_W-1:0]   pack_data;

    bldc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIST_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && (state_reg == ST_IDLE);
    assign in_byte       = s_axis_tdata[DATA_W-1:0];
    assign in_start      = s_axis_tuser[0];

    assign eff_phase = in_start ? PH_PAD : phase_reg;
    assign eff_flag  = in_start ? '0 : flag_reg;
    assign eff_skip  = in_start ? '0 : skip_reg;
    assign eff_dist  = in_start ? '0 : dist_reg;
    assign eff_prod  = in_start ? '0 : prod_reg;
    assign eff_err   = in_start ? 1'b0 : err_latch_reg;
    assign skip_dec  = (eff_skip != '0) ? eff_skip - 1'b1 : '0;

    assign put_val   = use_lit_reg ? lit_reg : ram_rdata;
    assign ram_raddr = prod_reg[HIST_AW-1:0] - dist_reg[HIST_AW-1:0];
    assign ram_waddr = prod_reg[HIST_AW-1:0];
    assign ram_wdata = put_val;

    always_comb
    begin
        pack_data = '0;
        for (int i = 0; i < LANE_SLOTS; i++)
        begin
            if (VC_W'(i) < fill_reg)
            begin
                pack_data[i*DATA_W +: DATA_W] = lane_reg[i];
            end
        end
        pack_data[LANE_SLOTS*DATA_W +: VC_W] = fill_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        skip_next      = skip_reg;
        dist_next      = dist_reg;
        prod_next      = prod_reg;
        err_latch_next = err_latch_reg;
        size_next      = size_reg;
        remain_next    = remain_reg;
        lit_next       = lit_reg;
        use_lit_next   = use_lit_reg;
        fill_next      = fill_reg;
        lane_next      = lane_reg;
        final_next     = final_reg;
        run_err_next   = run_err_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        ram_we         = 1'b0;

        if (cfg_we)
        begin
            size_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    phase_next     = eff_phase;
                    flag_next      = eff_flag;
                    skip_next      = eff_skip;
                    dist_next      = eff_dist;
                    prod_next      = eff_prod;
                    err_latch_next = eff_err;
                    fill_next      = '0;
                    run_err_next   = 1'b0;
                    final_next     = 1'b0;
                    if (!eff_err)
                    begin
                        unique case (eff_phase)
                            PH_PAD:
                            begin
                                if (in_byte != '0)
                                begin
                                    flag_next  = in_byte;
                                    skip_next  = TRAILER_W'(TRAILER_BYTES);
                                    phase_next = PH_TRAILER;
                                end
                            end
                            PH_TRAILER:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == '0)
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                            PH_BODY:
                            begin
                                if (in_byte == eff_flag)
                                begin
                                    phase_next = PH_FLAG;
                                end
                                else
                                begin
                                    lit_next     = in_byte;
                                    use_lit_next = 1'b1;
                                    remain_next  = RUN_W'(1);
                                    state_next   = ST_CHK;
                                end
                            end
                            PH_FLAG:
                            begin
                                if (in_byte == '0)
                                begin
                                    lit_next     = eff_flag;
                                    use_lit_next = 1'b1;
                                    remain_next  = RUN_W'(1);
                                    phase_next   = PH_BODY;
                                    state_next   = ST_CHK;
                                end
                                else
                                begin
                                    dist_next  = in_byte;
                                    phase_next = PH_LEN;
                                end
                            end
                            PH_LEN:
                            begin
                                phase_next = PH_BODY;
                                if (CNT_W'(eff_dist) > eff_prod)
                                begin
                                    run_err_next   = 1'b1;
                                    err_latch_next = 1'b1;
                                    final_next     = 1'b1;
                                    state_next     = ST_FLUSH;
                                end
                                else
                                begin
                                    use_lit_next = 1'b0;
                                    remain_next  = RUN_W'(in_byte) + RUN_W'(MIN_MATCH);
                                    state_next   = ST_CHK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_PAD;
                            end
                        endcase
                    end
                end
            end
            ST_CHK:
            begin
                if (remain_reg == '0)
                begin
                    final_next = 1'b1;
                    state_next = ST_FLUSH;
                end
                else if (prod_reg == size_reg)
                begin
                    run_err_next   = 1'b1;
                    err_latch_next = 1'b1;
                    final_next     = 1'b1;
                    state_next     = ST_FLUSH;
                end
                else if (fill_reg == VC_W'(LANES))
                begin
                    final_next = 1'b0;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                ram_we                          = 1'b1;
                lane_next[fill_reg[LANE_IDX_W-1:0]] = put_val;
                prod_next                       = prod_reg + 1'b1;
                fill_next                       = fill_reg + 1'b1;
                remain_next                     = remain_reg - 1'b1;
                state_next                      = ST_CHK;
            end
            ST_FLUSH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next           = 1'b1;
                    m_data_next            = pack_data;
                    m_last_next            = final_reg;
                    m_user_next[USER_ERR]  = final_reg && run_err_reg;
                    m_user_next[USER_DONE] = (prod_reg == size_reg);
                    fill_next              = '0;
                    state_next             = final_reg ? ST_IDLE : ST_CHK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PAD;
            flag_reg      <= '0;
            skip_reg      <= '0;
            dist_reg      <= '0;
            prod_reg      <= '0;
            err_latch_reg <= 1'b0;
            size_reg      <= '0;
            remain_reg    <= '0;
            fill_reg      <= '0;
            final_reg     <= 1'b0;
            run_err_reg   <= 1'b0;
            use_lit_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            skip_reg      <= skip_next;
            dist_reg      <= dist_next;
            prod_reg      <= prod_next;
            err_latch_reg <= err_latch_next;
            size_reg      <= size_next;
            remain_reg    <= remain_next;
            fill_reg      <= fill_next;
            final_reg     <= final_next;
            run_err_reg   <= run_err_next;
            use_lit_reg   <= use_lit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg    <= lit_next;
        lane_reg   <= lane_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ----- rtl/bldc_checker.sv -----
// Port-level checker for the decompressor, bound to the top level.
`timescale 1ns / 1ps

module bldc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bldc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic [bldc_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import bldc_pkg::*;

    logic [VC_W-1:0] vc;

    assign vc = m_axis_tdata[LANE_SLOTS*DATA_W +: VC_W];

    // An error is only ever reported on the closing group of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_ERR] |-> m_axis_tlast)
        else $error("error flag on a group that is not the last of its item");

    // A group with no bytes exists only to report an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (vc == '0) |-> m_axis_tuser[USER_ERR] && m_axis_tlast)
        else $error("empty group without an error");

    // Every group but the last of an item carries a full set of lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> vc == VC_W'(LANES))
        else $error("partial group before the end of an item");

    // A stalled group is held unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output group changed while stalled");

endmodule

bind backward_lz_flag_decompressor bldc_checker u_bldc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/backward_lz_flag_decompressor_tb.sv -----
// Testbench for the backward LZ flag-byte decompressor: directed table, then random streams.
`timescale 1ns / 1ps

module backward_lz_flag_decompressor_tb;

    import bldc_pkg::*;

    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 25;
    localparam int PHASE_COUNT   = 8;
    localparam int DIRECTED_ROWS = 29;
    localparam int VC_LSB        = LANE_SLOTS * DATA_W;

    typedef struct packed {
        logic [63:0] lanes;
        logic [3:0]  count;
        logic        last;
        logic        err;
        logic        done;
    } group_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_TYPED,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed {
        logic      start;
        logic [7:0] data;
        row_kind_t kind;
        group_t    res;
    } row_t;

    localparam group_t NO_GROUP = '0;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CNT_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    // Decoder state mirrored by the testbench.
    logic [31:0] size_reg;
    phase_t      phase;
    logic [7:0]  flag_val;
    logic [2:0]  trailer_left;
    logic [7:0]  copy_dist;
    logic [31:0] produced;
    logic        err_latch;
    logic [7:0]  hist [HIST_DEPTH];
    logic [7:0]  run_bytes [$];
    logic        run_fail;

    group_t      decoded_groups [$];
    group_t      expected_groups [$];
    int          mismatches = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 8'hAA, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h01, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h80, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h11, ROW_TYPED,   '{64'h0, 4'd0, 1'b1, 1'b1, 1'b1}},
        '{1'b0, 8'd11, ROW_SIZE,    NO_GROUP},
        '{1'b1, 8'h00, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h12, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h34, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_TYPED,   '{64'h0, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{1'b0, 8'h01, ROW_TYPED,   '{64'h01, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_TYPED,   '{64'hFF, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h02, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h05, ROW_PREDICT, NO_GROUP},
        '{1'b0, 8'h77, ROW_TYPED,   '{64'h0, 4'd0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, 8'h80, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h5A, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'hA5, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'hFF, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h80, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h03, ROW_SILENT,  NO_GROUP},
        '{1'b0, 8'h00, ROW_TYPED,   '{64'h0, 4'd0, 1'b1, 1'b1, 1'b0}}
    };

    backward_lz_flag_decompressor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic clear_stream();
        phase        = PH_PAD;
        flag_val     = 8'h00;
        trailer_left = 3'd0;
        copy_dist    = 8'h00;
        produced     = 32'd0;
        err_latch    = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] v);
        if (run_fail)
            return;
        if (produced >= size_reg)
        begin
            run_fail = 1'b1;
            return;
        end
        hist[produced[HIST_AW-1:0]] = v;
        produced++;
        run_bytes.push_back(v);
    endtask

    task automatic lz_decode_byte(input logic start, input logic [7:0] b);
        int          groups;
        int          cnt;
        int          total;
        logic [31:0] base;
        group_t      grp;
        logic [31:0] src;
        decoded_groups.delete();
        run_bytes.delete();
        run_fail     = 1'b0;
        if (start)
            clear_stream();
        if (err_latch)
            return;
        case (phase)
            PH_PAD:
            begin
                if (b != 8'h00)
                begin
                    flag_val     = b;
                    trailer_left = TRAILER_W'(TRAILER_BYTES);
                    phase        = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (trailer_left > 0)
                    trailer_left--;
                if (trailer_left == 0)
                    phase = PH_BODY;
            end
            PH_BODY:
            begin
                if (b == flag_val)
                    phase = PH_FLAG;
                else
                    emit_byte(b);
            end
            PH_FLAG:
            begin
                if (b == 8'h00)
                begin
                    emit_byte(flag_val);
                    phase = PH_BODY;
                end
                else
                begin
                    copy_dist = b;
                    phase     = PH_LEN;
                end
            end
            PH_LEN:
            begin
                phase = PH_BODY;
                if ({24'd0, copy_dist} > produced)
                    run_fail = 1'b1;
                else
                begin
                    for (int k = 0; k < int'(b) + MIN_MATCH && !run_fail; k++)
                    begin
                        src = produced - {24'd0, copy_dist};
                        emit_byte(hist[src[HIST_AW-1:0]]);
                    end
                end
            end
            default:
                phase = PH_PAD;
        endcase
        if (run_fail)
            err_latch = 1'b1;
        total = run_bytes.size();
        if (total == 0 && !run_fail)
            return;
        groups = (total == 0) ? 1 : (total + LANES - 1) / LANES;
        base   = produced - 32'(total);
        for (int g = 0; g < groups; g++)
        begin
            cnt = total - g * LANES;
            if (cnt > LANES)
                cnt = LANES;
            if (cnt < 0)
                cnt = 0;
            grp = NO_GROUP;
            for (int k = 0; k < cnt; k++)
                grp.lanes[8*k +: 8] = run_bytes[g * LANES + k];
            grp.count = 4'(cnt);
            grp.last  = (g == groups - 1);
            grp.err   = grp.last && run_fail;
            grp.done  = ((base + 32'(g * LANES + cnt)) == size_reg);
            decoded_groups.push_back(grp);
        end
    endtask

    task automatic send_byte(input logic start, input logic [7:0] b, input bit keep);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lz_decode_byte(start, b);
        if (keep)
            foreach (decoded_groups[i])
                expected_groups.push_back(decoded_groups[i]);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg   = v;
    endtask

    task automatic send_random_stream(inout int taken);
        logic [7:0] stream_q [$];
        logic [7:0] flag;
        logic [7:0] lit;
        int         est;
        int         choice;
        int         limit;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(4, 20))
                stream_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            est = 0;
            repeat ($urandom_range(0, 3))
                stream_q.push_back(8'h00);
            flag = 8'($urandom_range(1, 255));
            stream_q.push_back(flag);
            repeat (TRAILER_BYTES)
                stream_q.push_back(8'($urandom_range(0, 255)));
            for (int t = $urandom_range(4, 24); t > 0; t--)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 55)
                begin
                    lit = 8'($urandom_range(0, 255));
                    if (lit == flag)
                        lit = lit ^ 8'h01;
                    stream_q.push_back(lit);
                    est++;
                end
                else if (choice < 67 || (choice < 95 && est == 0))
                begin
                    stream_q.push_back(flag);
                    stream_q.push_back(8'h00);
                    est++;
                end
                else if (choice < 95)
                begin
                    limit = (est > 255) ? 255 : est;
                    stream_q.push_back(flag);
                    stream_q.push_back(8'($urandom_range(1, limit)));
                    lit = ($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, 12));
                    stream_q.push_back(lit);
                    est += int'(lit) + MIN_MATCH;
                end
                else if (est < 255)
                begin
                    stream_q.push_back(flag);
                    stream_q.push_back(8'($urandom_range(est + 1, 255)));
                    stream_q.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    stream_q.push_back(flag);
                    break;
                end
            end
        end
        foreach (stream_q[i])
        begin
            if (taken >= PHASE_ITEMS)
                break;
            send_byte(i == 0, stream_q[i], 1'b1);
            taken++;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s: expected %0h, got %0h at %0t", name, want, got,
                         $realtime);
        end
    endtask

    task automatic check_group();
        group_t want;
        if (expected_groups.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected output item: tdata %h tlast %b tuser %b at %0t",
                         m_axis_tdata, m_axis_tlast, m_axis_tuser, $realtime);
            return;
        end
        want = expected_groups.pop_front();
        for (int k = 0; k < LANE_SLOTS; k++)
            compare_field($sformatf("out_byte_%0d", k), 32'(want.lanes[8*k +: 8]),
                          32'(m_axis_tdata[8*k +: 8]));
        compare_field("valid_count", 32'(want.count), 32'(m_axis_tdata[VC_LSB +: VC_W]));
        compare_field("run_last", 32'(want.last), 32'(m_axis_tlast));
        compare_field("decode_error", 32'(want.err), 32'(m_axis_tuser[USER_ERR]));
        compare_field("stream_done", 32'(want.done), 32'(m_axis_tuser[USER_DONE]));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_group();
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                m_axis_tready <= 1'b1;
        end
        else if (rst_n && !calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end
    end

    initial
    begin
        int          taken;
        logic [31:0] next_size;
        size_reg = 32'd0;
        clear_stream();
        foreach (hist[i])
            hist[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_SIZE)
            begin
                wait_until_idle();
                write_size({24'd0, directed_rows[r].data});
            end
            else
            begin
                send_byte(directed_rows[r].start, directed_rows[r].data,
                          directed_rows[r].kind == ROW_PREDICT);
                if (directed_rows[r].kind == ROW_TYPED)
                    expected_groups.push_back(directed_rows[r].res);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       next_size = 32'hFFFF_FFFF;
                1:       next_size = 32'($urandom_range(16, 120));
                2:       next_size = 32'd1;
                3:       next_size = $urandom();
                4:       next_size = 32'd0;
                5:       next_size = 32'($urandom_range(40, 400));
                6:       next_size = 32'd300;
                default: next_size = 32'hFFFF_FFFF;
            endcase
            wait_until_idle();
            write_size(next_size);
            calm  = (p == PHASE_COUNT - 1);
            taken = 0;
            while (taken < PHASE_ITEMS)
                send_random_stream(taken);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bldc_pkg.sv
rtl/bldc_ram.sv
rtl/backward_lz_flag_decompressor.sv
rtl/bldc_checker.sv
dv/backward_lz_flag_decompressor_tb.sv
